// File: rtl/crps_pkg.sv
// Shared constants for the Catmull-Rom point and slope evaluator.
package crps_pkg;

  // Fraction bits of the curve parameter (Q1.FRAC_BITS, 2^FRAC_BITS is one).
  localparam int unsigned FRAC_BITS = 16;

  // Width of the Q16.16 control values and results.
  localparam int unsigned VAL_W = 32;

  // Coefficient widths: c0..c3 fit 36 signed bits, 3*c3 fits 38.
  localparam int unsigned COEF_W  = 36;
  localparam int unsigned COEF3_W = 38;

  // Pipeline depth, input register through output register.
  localparam int unsigned NUM_STAGES = 6;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

// File: rtl/crps_if.sv
// Valid/ready channel interfaces for the Catmull-Rom evaluator.
interface crps_in_if #(
  parameter int unsigned FracBits = crps_pkg::FRAC_BITS
);
  import crps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] ctrl_before;
  logic signed [VAL_W-1:0] seg_start;
  logic signed [VAL_W-1:0] seg_end;
  logic signed [VAL_W-1:0] ctrl_after;
  logic [FracBits:0]       param_t;

  modport source (
    output valid, ctrl_before, seg_start, seg_end, ctrl_after, param_t,
    input  ready
  );
  modport sink (
    input  valid, ctrl_before, seg_start, seg_end, ctrl_after, param_t,
    output ready
  );
endinterface

interface crps_out_if;
  import crps_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] curve_value;
  logic signed [VAL_W-1:0] curve_slope;
  logic                    sat_flag;

  modport source (
    output valid, curve_value, curve_slope, sat_flag,
    input  ready
  );
  modport sink (
    input  valid, curve_value, curve_slope, sat_flag,
    output ready
  );
endinterface

// File: rtl/crps_sat.sv
// Floor shift of a wide signed value and saturation to the result width.
module crps_sat #(
  parameter int unsigned InW   = 90,
  parameter int unsigned Shift = 49
) (
  input  logic signed [InW-1:0]             din_i,
  output logic signed [crps_pkg::VAL_W-1:0] dout_o,
  output logic                              sat_o
);
  import crps_pkg::*;

  localparam int unsigned KeepW = InW - Shift;

  logic [KeepW-1:0]       kept;
  logic [KeepW-VAL_W:0]   top_bits;
  logic                   fits;

  // Dropping the low bits of a two's complement value floors it.
  assign kept     = din_i[InW-1:Shift];
  assign top_bits = kept[KeepW-1:VAL_W-1];
  assign fits     = (&top_bits) || !(|top_bits);

  always_comb begin
    if (fits) begin
      dout_o = kept[VAL_W-1:0];
    end else if (kept[KeepW-1]) begin
      dout_o = VAL_MIN;
    end else begin
      dout_o = VAL_MAX;
    end
  end

  assign sat_o = !fits;

endmodule

// File: rtl/catmull_rom_point_and_slope.sv
// Top level: pipelined uniform Catmull-Rom value and slope evaluator.
//
//   channel | port  | dir | beat contents
//   --------+-------+-----+-----------------------------------------------------
//   input   | in_i  | in  | ctrl_before, seg_start, seg_end, ctrl_after, param_t
//   result  | out_o | out | curve_value, curve_slope, sat_flag
//
// One beat is accepted per cycle while the result side does not stall a full pipe;
// each beat passes through six register stages (coefficients, first Horner step, second
// Horner step, split partial products, final sum, floor/saturate output register).
// Every stage carries a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles collapse while the result side stalls.
// Reset (rst_ni low, asynchronous) clears the valid bits only.
module catmull_rom_point_and_slope #(
  parameter int unsigned FracBits = crps_pkg::FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  crps_in_if.sink   in_i,
  crps_out_if.source out_o
);
  import crps_pkg::*;

  // t is unsigned TW bits; as a signed multiplier operand it takes MW bits.
  localparam int unsigned TW  = FracBits + 1;
  localparam int unsigned MW  = TW + 1;
  // Horner accumulator widths, each one multiply by t wider than the last.
  localparam int unsigned A1W = COEF_W + MW;
  localparam int unsigned A2W = A1W + MW;
  localparam int unsigned A3W = A2W + MW;
  localparam int unsigned B1W = COEF3_W + MW;
  localparam int unsigned B2W = B1W + MW;
  // The last value multiply is split into a low unsigned and a high signed half.
  localparam int unsigned AL  = A2W / 2;
  localparam int unsigned PLW = AL + TW;
  localparam int unsigned PHW = A2W - AL + MW;

  // ---------------------------------------------------------------------------
  // Handshake: per-stage valid bits and a ready chain from the output back.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = in_i.valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_i.ready = rdy[0];

  // ---------------------------------------------------------------------------
  // Stage 1: control values to polynomial coefficients (all times two).
  //   c0 = 2*p1, c1 = p2 - p0, c2 = 2*p0 - 5*p1 + 4*p2 - p3,
  //   c3 = 3*p1 - 3*p2 + p3 - p0, plus 3*c3 for the slope.
  // ---------------------------------------------------------------------------
  logic signed [COEF_W-1:0]  p0, p1, p2, p3;
  logic signed [COEF3_W-1:0] q0, q1, q2, q3;
  logic signed [COEF_W-1:0]  c0_d, c1_d, c2_d, c3_d;
  logic signed [COEF3_W-1:0] c3x3_d;
  logic [TW-1:0]             t_d;

  always_comb begin
    p0 = {{(COEF_W-VAL_W){in_i.ctrl_before[VAL_W-1]}}, in_i.ctrl_before};
    p1 = {{(COEF_W-VAL_W){in_i.seg_start[VAL_W-1]}},   in_i.seg_start};
    p2 = {{(COEF_W-VAL_W){in_i.seg_end[VAL_W-1]}},     in_i.seg_end};
    p3 = {{(COEF_W-VAL_W){in_i.ctrl_after[VAL_W-1]}},  in_i.ctrl_after};
    q0 = {{(COEF3_W-VAL_W){in_i.ctrl_before[VAL_W-1]}}, in_i.ctrl_before};
    q1 = {{(COEF3_W-VAL_W){in_i.seg_start[VAL_W-1]}},   in_i.seg_start};
    q2 = {{(COEF3_W-VAL_W){in_i.seg_end[VAL_W-1]}},     in_i.seg_end};
    q3 = {{(COEF3_W-VAL_W){in_i.ctrl_after[VAL_W-1]}},  in_i.ctrl_after};

    c0_d   = p1 <<< 1;
    c1_d   = p2 - p0;
    c2_d   = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
    c3_d   = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - p0;
    // 3*c3 straight from the inputs so it sits beside c3, not after it.
    c3x3_d = (q1 <<< 3) + q1 - (q2 <<< 3) - q2 + (q3 <<< 1) + q3 - (q0 <<< 1) - q0;
    // Bits above FracBits are not part of t.
    t_d    = in_i.param_t[FracBits:0];
  end

  logic signed [COEF_W-1:0]  c0_s1_q, c1_s1_q, c2_s1_q, c3_s1_q;
  logic signed [COEF3_W-1:0] c3x3_s1_q;
  logic [TW-1:0]             t_s1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      c0_s1_q   <= c0_d;
      c1_s1_q   <= c1_d;
      c2_s1_q   <= c2_d;
      c3_s1_q   <= c3_d;
      c3x3_s1_q <= c3x3_d;
      t_s1_q    <= t_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: first Horner step for both polynomials.
  //   a1 = c3*t + c2*S,  b1 = 3*c3*t + 2*c2*S  (S = 2^FracBits)
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0]  t1s;
  logic signed [A1W-1:0] m_a1, c2_a1, a1_d;
  logic signed [B1W-1:0] m_b1, c2_b1, b1_d;

  always_comb begin
    t1s   = $signed({1'b0, t_s1_q});
    m_a1  = c3_s1_q * t1s;
    m_b1  = c3x3_s1_q * t1s;
    c2_a1 = {{(A1W-COEF_W){c2_s1_q[COEF_W-1]}}, c2_s1_q};
    c2_b1 = {{(B1W-COEF_W){c2_s1_q[COEF_W-1]}}, c2_s1_q};
    a1_d  = m_a1 + (c2_a1 <<< FracBits);
    b1_d  = m_b1 + (c2_b1 <<< (FracBits + 1));
  end

  logic signed [A1W-1:0]    a1_s2_q;
  logic signed [B1W-1:0]    b1_s2_q;
  logic signed [COEF_W-1:0] c0_s2_q, c1_s2_q;
  logic [TW-1:0]            t_s2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      a1_s2_q <= a1_d;
      b1_s2_q <= b1_d;
      c0_s2_q <= c0_s1_q;
      c1_s2_q <= c1_s1_q;
      t_s2_q  <= t_s1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: second Horner step; the slope polynomial is complete here.
  //   a2 = a1*t + c1*S^2,  b2 = b1*t + c1*S^2
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0]  t2s;
  logic signed [A2W-1:0] m_a2, c1_a2, a2_d;
  logic signed [B2W-1:0] m_b2, c1_b2, b2_d;

  always_comb begin
    t2s   = $signed({1'b0, t_s2_q});
    m_a2  = a1_s2_q * t2s;
    m_b2  = b1_s2_q * t2s;
    c1_a2 = {{(A2W-COEF_W){c1_s2_q[COEF_W-1]}}, c1_s2_q};
    c1_b2 = {{(B2W-COEF_W){c1_s2_q[COEF_W-1]}}, c1_s2_q};
    a2_d  = m_a2 + (c1_a2 <<< (2 * FracBits));
    b2_d  = m_b2 + (c1_b2 <<< (2 * FracBits));
  end

  logic signed [A2W-1:0]    a2_s3_q;
  logic signed [B2W-1:0]    b2_s3_q;
  logic signed [COEF_W-1:0] c0_s3_q;
  logic [TW-1:0]            t_s3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      a2_s3_q <= a2_d;
      b2_s3_q <= b2_d;
      c0_s3_q <= c0_s2_q;
      t_s3_q  <= t_s2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: split the wide a2*t into two partial products; floor and
  // saturate the slope (b2 carries a factor 2*S^2).
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0]    t3s;
  logic [PLW-1:0]          pl_d;
  logic signed [PHW-1:0]   ph_d;
  logic signed [VAL_W-1:0] slope_d;
  logic                    slope_sat_d;

  always_comb begin
    t3s  = $signed({1'b0, t_s3_q});
    pl_d = a2_s3_q[AL-1:0] * t_s3_q;
    ph_d = $signed(a2_s3_q[A2W-1:AL]) * t3s;
  end

  crps_sat #(
    .InW   (B2W),
    .Shift (2 * FracBits + 1)
  ) u_slope_sat (
    .din_i  (b2_s3_q),
    .dout_o (slope_d),
    .sat_o  (slope_sat_d)
  );

  logic [PLW-1:0]           pl_s4_q;
  logic signed [PHW-1:0]    ph_s4_q;
  logic signed [COEF_W-1:0] c0_s4_q;
  logic signed [VAL_W-1:0]  slope_s4_q;
  logic                     slope_sat_s4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      pl_s4_q        <= pl_d;
      ph_s4_q        <= ph_d;
      c0_s4_q        <= c0_s3_q;
      slope_s4_q     <= slope_d;
      slope_sat_s4_q <= slope_sat_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: join the partial products and add c0*S^3.
  // ---------------------------------------------------------------------------
  logic signed [A3W-1:0] ph_a3, pl_a3, c0_a3, a3_d;

  always_comb begin
    ph_a3 = {{(A3W-PHW){ph_s4_q[PHW-1]}}, ph_s4_q};
    pl_a3 = {{(A3W-PLW){1'b0}}, pl_s4_q};
    c0_a3 = {{(A3W-COEF_W){c0_s4_q[COEF_W-1]}}, c0_s4_q};
    a3_d  = (ph_a3 <<< AL) + pl_a3 + (c0_a3 <<< (3 * FracBits));
  end

  logic signed [A3W-1:0]   a3_s5_q;
  logic signed [VAL_W-1:0] slope_s5_q;
  logic                    slope_sat_s5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      a3_s5_q        <= a3_d;
      slope_s5_q     <= slope_s4_q;
      slope_sat_s5_q <= slope_sat_s4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: floor and saturate the value (a3 carries 2*S^3); output register.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] value_d;
  logic                    value_sat_d;

  crps_sat #(
    .InW   (A3W),
    .Shift (3 * FracBits + 1)
  ) u_value_sat (
    .din_i  (a3_s5_q),
    .dout_o (value_d),
    .sat_o  (value_sat_d)
  );

  logic signed [VAL_W-1:0] value_s6_q, slope_s6_q;
  logic                    sat_s6_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      value_s6_q <= value_d;
      slope_s6_q <= slope_s5_q;
      sat_s6_q   <= value_sat_d || slope_sat_s5_q;
    end
  end

  assign out_o.valid       = vld_q[NUM_STAGES-1];
  assign out_o.curve_value = value_s6_q;
  assign out_o.curve_slope = slope_s6_q;
  assign out_o.sat_flag    = sat_s6_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // With nothing waiting at the output, the pipe can always take a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled while output register is empty");

  // A blocked first stage keeps its item, its c0 coefficient and its t.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !rdy[1]) |=> (vld_q[0] && $stable(c0_s1_q) && $stable(t_s1_q)))
    else $error("stage 1 item lost or changed during stall");

  // Stage 3 moving while stage 4 is full must find stage 4 moving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && rdy[2]) |-> (!vld_q[3] || rdy[3]))
    else $error("stage 3 overwritten while stage 4 held");

  // Results strictly inside the range never carry the saturation flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.curve_value != VAL_MAX && out_o.curve_value != VAL_MIN &&
     out_o.curve_slope != VAL_MAX && out_o.curve_slope != VAL_MIN) |-> !out_o.sat_flag)
    else $error("saturation flag set on in-range results");

endmodule
